[hdl/sqv_pkg.sv]
// Shared types, widths and constants of the sprite quad vertex generator.
package sqv_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned NCELLS       = 17;
  localparam int unsigned CS_W         = 19;
  localparam int unsigned Z_W          = 18;
  localparam int unsigned OFS_W        = 26;
  localparam int unsigned SC_W         = 42;
  localparam int unsigned HALF_W       = 21;
  localparam int unsigned PROD_W       = 62;
  localparam int unsigned RND_W        = 39;
  localparam int unsigned SUM_W        = 40;
  localparam int unsigned SIZE_W       = 13;
  localparam int unsigned Q_W          = 17;
  localparam int unsigned IN_W         = 224;
  localparam int unsigned OUT_W        = 120;

  localparam logic signed [CS_W-1:0] CORDIC_START = 19'sd19898;
  localparam logic signed [CS_W-1:0] ONE_Q15      = 19'sd32768;
  localparam logic [Q_W-1:0]         UV_MAX       = 17'd131071;

  localparam logic CFG_TEX_W = 1'b0;
  localparam logic CFG_TEX_H = 1'b1;

  typedef struct packed {
    logic                          valid;
    logic signed [CS_W-1:0]        x;
    logic signed [CS_W-1:0]        y;
    logic signed [Z_W-1:0]         z;
    logic                          neg;
    logic                          zero;
    logic [3:0][SIZE_W-1:0]        rem;
    logic [3:0][Q_W-1:0]           nlo;
    logic [3:0][Q_W-1:0]           quo;
    logic [3:0]                    sat;
    logic signed [OFS_W-1:0]       ax0;
    logic signed [OFS_W-1:0]       ax1;
    logic signed [OFS_W-1:0]       ay0;
    logic signed [OFS_W-1:0]       ay1;
    logic [15:0]                   scx;
    logic [15:0]                   scy;
    logic signed [24:0]            wx;
    logic signed [24:0]            wy;
    logic [31:0]                   tint;
  } pipe_t;

  typedef struct packed {
    logic signed [24:0] wx;
    logic signed [24:0] wy;
    logic [31:0]        tint;
    logic [3:0][Q_W-1:0] uv;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned i);
    logic signed [Z_W-1:0] r;
    begin
      unique case (i)
        0:       r = 18'sd8192;
        1:       r = 18'sd4836;
        2:       r = 18'sd2555;
        3:       r = 18'sd1297;
        4:       r = 18'sd651;
        5:       r = 18'sd326;
        6:       r = 18'sd163;
        7:       r = 18'sd81;
        8:       r = 18'sd41;
        9:       r = 18'sd20;
        10:      r = 18'sd10;
        11:      r = 18'sd5;
        12:      r = 18'sd3;
        13:      r = 18'sd1;
        14:      r = 18'sd1;
        default: r = 18'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

[hdl/sqv_front.sv]
// Input stage: unpacks a sprite, folds the angle, builds offsets and divider operands.
module sqv_front import sqv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_data,
  input  logic [SIZE_W-1:0] tw,
  input  logic [SIZE_W-1:0] th,
  output pipe_t             q
);

  pipe_t                   q_r;
  pipe_t                   q_nxt;
  logic signed [23:0]      px, py, ox, oy;
  logic [15:0]             ang;
  logic [11:0]             sx, sy, sw, sh;
  logic signed [Z_W-1:0]   z0;
  logic                    size_zero;
  logic                    rect_zero;
  logic [SIZE_W-1:0]       cw, ch;
  logic [3:0][SIZE_W-1:0]  pix;
  logic [3:0][SIZE_W-1:0]  dv;
  logic [3:0][28:0]        num;

  always_comb begin
    px  = in_data[23:0];
    py  = in_data[47:24];
    ox  = in_data[71:48];
    oy  = in_data[95:72];
    ang = in_data[143:128];
    sx  = in_data[155:144];
    sy  = in_data[167:156];
    sw  = in_data[179:168];
    sh  = in_data[191:180];

    size_zero = (sw == 12'd0) && (sh == 12'd0);
    rect_zero = size_zero && (sx == 12'd0) && (sy == 12'd0);
    cw = size_zero ? tw : {1'b0, sw};
    ch = size_zero ? th : {1'b0, sh};

    z0 = Z_W'($signed(ang));
    q_nxt.neg = 1'b0;
    if (z0 > 18'sd16384) begin
      z0 = z0 - 18'sd32768;
      q_nxt.neg = 1'b1;
    end else if (z0 < -18'sd16384) begin
      z0 = z0 + 18'sd32768;
      q_nxt.neg = 1'b1;
    end

    q_nxt.valid = in_valid;
    q_nxt.x     = CORDIC_START;
    q_nxt.y     = '0;
    q_nxt.z     = z0;
    q_nxt.zero  = (ang == 16'd0);

    pix[0] = {1'b0, sx};
    pix[1] = rect_zero ? tw : SIZE_W'({1'b0, sx} + {1'b0, sw});
    pix[2] = {1'b0, sy};
    pix[3] = rect_zero ? th : SIZE_W'({1'b0, sy} + {1'b0, sh});
    dv[0] = tw;
    dv[1] = tw;
    dv[2] = th;
    dv[3] = th;
    for (int k = 0; k < 4; k++) begin
      num[k] = {pix[k], 16'd0} + 29'(dv[k] >> 1);
      q_nxt.rem[k] = {1'b0, num[k][28:17]};
      q_nxt.sat[k] = ({1'b0, num[k][28:17]} >= dv[k]);
      q_nxt.nlo[k] = num[k][16:0];
      q_nxt.quo[k] = '0;
    end

    q_nxt.ax0  = -OFS_W'(ox);
    q_nxt.ay0  = -OFS_W'(oy);
    q_nxt.ax1  = $signed(OFS_W'({cw, 8'd0})) - OFS_W'(ox);
    q_nxt.ay1  = $signed(OFS_W'({ch, 8'd0})) - OFS_W'(oy);
    q_nxt.scx  = in_data[111:96];
    q_nxt.scy  = in_data[127:112];
    q_nxt.wx   = 25'(px) + 25'(ox);
    q_nxt.wy   = 25'(py) + 25'(oy);
    q_nxt.tint = in_data[223:192];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[hdl/sqv_cell.sv]
// Chain cell: CORDIC step if IDX < CORDIC_STEPS; a quotient bit for each of four UV lanes.
module sqv_cell import sqv_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [SIZE_W-1:0] tw,
  input  logic [SIZE_W-1:0] th,
  input  pipe_t             d,
  output pipe_t             q
);

  pipe_t                  q_r;
  pipe_t                  q_nxt;
  logic [SIZE_W:0]        r2;
  logic [SIZE_W-1:0]      dv;
  logic                   ge;

  always_comb begin
    q_nxt = d;
    if (IDX < CORDIC_STEPS) begin
      if (d.z >= 0) begin
        q_nxt.x = d.x - (d.y >>> IDX);
        q_nxt.y = d.y + (d.x >>> IDX);
        q_nxt.z = d.z - atan_lut(IDX);
      end else begin
        q_nxt.x = d.x + (d.y >>> IDX);
        q_nxt.y = d.y - (d.x >>> IDX);
        q_nxt.z = d.z + atan_lut(IDX);
      end
    end
    for (int k = 0; k < 4; k++) begin
      dv = (k < 2) ? tw : th;
      r2 = {d.rem[k], d.nlo[k][Q_W-1]};
      ge = (r2 >= {1'b0, dv});
      q_nxt.rem[k] = ge ? SIZE_W'(r2 - {1'b0, dv}) : SIZE_W'(r2);
      q_nxt.nlo[k] = {d.nlo[k][Q_W-2:0], 1'b0};
      q_nxt.quo[k] = {d.quo[k][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[hdl/sqv_back.sv]
// Back end: scaling, rotation products, rounding, saturation and the four-vertex output register.
module sqv_back import sqv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_t              d,
  output logic               en,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_data,
  output logic [1:0]         out_corner,
  output logic               out_last
);

  // stage 1: scaled offsets, sine and cosine
  logic                          v1_r;
  side_t                         sd1_r;
  logic signed [CS_W-1:0]        c1_r, s1_r;
  logic signed [3:0][SC_W-1:0]   o1_r;
  logic signed [OFS_W+16:0]      sp [4];
  logic signed [OFS_W-1:0]       of [4];
  side_t                         sd1_nxt;

  // stage 2: partial products
  logic                          v2_r;
  side_t                         sd2_r;
  logic signed [40:0]            plo_r [8];
  logic signed [39:0]            phi_r [8];

  // stage 3: full products, 0..3 cosine times offset, 4..7 sine times offset
  logic                          v3_r;
  side_t                         sd3_r;
  logic signed [PROD_W-1:0]      pr_r [8];

  // stage 4: rounded rotated offsets per corner
  logic                          v4_r;
  side_t                         sd4_r;
  logic signed [RND_W-1:0]       rx_r [4];
  logic signed [RND_W-1:0]       ry_r [4];

  // stage 5: output register
  logic                          v5_r;
  logic [1:0]                    cnt_r;
  logic [31:0]                   tint5_r;
  logic [3:0][23:0]              vx5_r, vy5_r;
  logic [3:0][Q_W-1:0]           uv5_r;

  logic signed [PROD_W-1:0]      sx4 [4];
  logic signed [PROD_W-1:0]      sy4 [4];
  logic signed [SUM_W-1:0]       ax5 [4];
  logic signed [SUM_W-1:0]       ay5 [4];
  logic [3:0][23:0]              vx5_nxt, vy5_nxt;

  assign en = !v5_r || (out_ready && (cnt_r == 2'd3));

  always_comb begin
    of[0] = d.ax0;
    of[1] = d.ax1;
    of[2] = d.ay0;
    of[3] = d.ay1;
    for (int k = 0; k < 4; k++) begin
      sp[k] = of[k] * $signed({1'b0, (k < 2) ? d.scx : d.scy});
    end
    sd1_nxt.wx   = d.wx;
    sd1_nxt.wy   = d.wy;
    sd1_nxt.tint = d.tint;
    for (int k = 0; k < 4; k++) begin
      sd1_nxt.uv[k] = d.sat[k] ? UV_MAX : d.quo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r <= sd1_nxt;
      for (int k = 0; k < 4; k++) begin
        o1_r[k] <= sp[k][SC_W-1:0];
      end
      if (d.zero) begin
        c1_r <= ONE_Q15;
        s1_r <= '0;
      end else begin
        c1_r <= d.neg ? -d.x : d.x;
        s1_r <= d.neg ? -d.y : d.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r <= sd1_r;
      for (int k = 0; k < 8; k++) begin
        plo_r[k] <= $signed({1'b0, o1_r[k%4][HALF_W-1:0]}) * ((k < 4) ? c1_r : s1_r);
        phi_r[k] <= $signed(o1_r[k%4][SC_W-1:HALF_W]) * ((k < 4) ? c1_r : s1_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r <= sd2_r;
      for (int k = 0; k < 8; k++) begin
        pr_r[k] <= (PROD_W'(phi_r[k]) <<< HALF_W) + PROD_W'(plo_r[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sx4[k] = pr_r[k & 1] - pr_r[6 + (k >> 1)] + (PROD_W'(1) <<< 22);
      sy4[k] = pr_r[4 + (k & 1)] + pr_r[2 + (k >> 1)] + (PROD_W'(1) <<< 22);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r <= sd3_r;
      for (int k = 0; k < 4; k++) begin
        rx_r[k] <= RND_W'(sx4[k] >>> 23);
        ry_r[k] <= RND_W'(sy4[k] >>> 23);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ax5[k] = SUM_W'(rx_r[k]) + SUM_W'(sd4_r.wx);
      ay5[k] = SUM_W'(ry_r[k]) + SUM_W'(sd4_r.wy);
      if (ax5[k] > 40'sd8388607) begin
        vx5_nxt[k] = 24'h7FFFFF;
      end else if (ax5[k] < -40'sd8388608) begin
        vx5_nxt[k] = 24'h800000;
      end else begin
        vx5_nxt[k] = ax5[k][23:0];
      end
      if (ay5[k] > 40'sd8388607) begin
        vy5_nxt[k] = 24'h7FFFFF;
      end else if (ay5[k] < -40'sd8388608) begin
        vy5_nxt[k] = 24'h800000;
      end else begin
        vy5_nxt[k] = ay5[k][23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx5_r   <= vx5_nxt;
      vy5_r   <= vy5_nxt;
      uv5_r   <= sd4_r.uv;
      tint5_r <= sd4_r.tint;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (en) begin
        v1_r  <= d.valid;
        v2_r  <= v1_r;
        v3_r  <= v2_r;
        v4_r  <= v3_r;
        v5_r  <= v4_r;
        cnt_r <= 2'd0;
      end else if (out_ready) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  assign out_valid  = v5_r;
  assign out_corner = cnt_r;
  assign out_last   = (cnt_r == 2'd3);
  assign out_data   = {6'd0, tint5_r, uv5_r[2 + cnt_r[1]], uv5_r[cnt_r[0]],
                       vy5_r[cnt_r], vx5_r[cnt_r]};

endmodule

[hdl/sprite_quad_vertex_gen.sv]
// Top level of the sprite quad vertex generator.
//
// Usage: one sprite transaction on the in_ channel yields four vertex transactions
// on the out_ channel, in the order top-left, top-right, bottom-left, bottom-right;
// out_tuser carries the corner number and out_tlast marks the fourth vertex.
// The user writes the texture size registers through cfg_ (index 0 width, 1 height)
// only while no sprite is in flight; the block does not enforce it. A zero size acts as one.
// Flow: a sprite passes the front-end register, a 17-cell CORDIC/divider chain
// and a 5-stage back end before its first vertex; then one vertex per cycle
// while out_tready is high. The single output port sets the sprite rate; the
// front end, the chain and the back end all advance together and take a new
// sprite each cycle the output register can be refilled.
// Reset: synchronous, active low; clears all valid bits and sets both texture
// sizes to one.
// Stall: while the output register holds a sprite the whole chain holds and
// in_tready stays low until its last vertex is taken, however long out_tready is low.
module sprite_quad_vertex_gen import sqv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // pos_x, pos_y, origin_x, origin_y, scale_x, scale_y, angle, src_x, src_y,
  // src_w, src_h, tint
  input  logic [IN_W-1:0]    in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // vertex_x, vertex_y, tex_u, tex_v, vertex_tint, zero fill
  output logic [OUT_W-1:0]   out_tdata,
  // corner
  output logic [1:0]         out_tuser,
  output logic               out_tlast,
  input  logic               cfg_wr_en,
  input  logic               cfg_addr,
  input  logic [SIZE_W-1:0]  cfg_wr_data
);

  logic [SIZE_W-1:0] tex_w_r, tex_h_r;
  logic [SIZE_W-1:0] tw, th;
  logic              en;
  pipe_t             chain [NCELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= SIZE_W'(1);
      tex_h_r <= SIZE_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_TEX_W: tex_w_r <= cfg_wr_data;
        CFG_TEX_H: tex_h_r <= cfg_wr_data;
        default:   tex_w_r <= tex_w_r;
      endcase
    end
  end

  assign tw = (tex_w_r == '0) ? SIZE_W'(1) : tex_w_r;
  assign th = (tex_h_r == '0) ? SIZE_W'(1) : tex_h_r;
  assign in_tready = en;

  sqv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .tw       (tw),
    .th       (th),
    .q        (chain[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    sqv_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tw    (tw),
      .th    (th),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  sqv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .d          (chain[NCELLS]),
    .en         (en),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_corner (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
